// File: hw/rtl/rpn_pkg.sv
// shared types and constants for the ray pick of the nearest point
`timescale 1ns / 1ps
package rpn_pkg;

    // capacity of the point counter per query
    localparam int POINT_CAP  = 65536;
    localparam int CNT_W      = $clog2(POINT_CAP + 1);
    localparam int IDX_W      = 16;

    // 0.01 as a Q0.24 fraction
    localparam logic [17:0] SCORE_K     = 18'd167772;
    localparam int          SCORE_SHIFT = 24;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_MAX_DIST = 3'd6
    } reg_index_t;

    // ray held in configuration
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic        [31:0] max_dist;
    } ray_cfg_t;

    // one classified point as queued for the back end
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [IDX_W-1:0]   pos;
        logic               score_en;
        logic               last;
        logic               ovf;
    } pt_entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: hw/rtl/rpn_queue.sv
// short fifo of classified points between front and back
`timescale 1ns / 1ps
module rpn_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rpn_pkg::pt_entry_t push_data,
    input  logic               pop,
    output rpn_pkg::pt_entry_t head,
    output rpn_pkg::q_stat_t   stat
);

    rpn_pkg::pt_entry_t mem_reg [rpn_pkg::Q_DEPTH];
    logic [rpn_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rpn_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rpn_pkg::Q_AW:0]   cnt_reg, cnt_next;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == (rpn_pkg::Q_AW + 1)'(rpn_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

// File: hw/rtl/rpn_front.sv
// input side: accepts points, numbers them and flags capacity overflow
`timescale 1ns / 1ps
module rpn_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic                last_point,
    input  rpn_pkg::q_stat_t    q_stat,
    output logic                push,
    output rpn_pkg::pt_entry_t  push_data
);

    logic [rpn_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      ovf_reg, ovf_next;
    logic                      in_room;

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;
    assign in_room  = (cnt_reg < rpn_pkg::CNT_W'(rpn_pkg::POINT_CAP));

    // classify the beat
    always_comb
    begin
        push_data.px       = point_x;
        push_data.py       = point_y;
        push_data.pz       = point_z;
        push_data.pos      = rpn_pkg::IDX_W'(cnt_reg);
        push_data.score_en = in_room;
        push_data.last     = last_point;
        push_data.ovf      = ovf_reg || !in_room;
    end

    // counter and overflow, cleared at the end of a query
    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (push)
        begin
            if (last_point)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else if (in_room)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// File: hw/rtl/rpn_back.sv
// scoring side: distances, square roots, best tracking and result register
`timescale 1ns / 1ps
module rpn_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  rpn_pkg::ray_cfg_t   cfg,
    input  rpn_pkg::pt_entry_t  head,
    input  rpn_pkg::q_stat_t    q_stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [15:0]         best_index,
    output logic signed [31:0]  hit_x,
    output logic signed [31:0]  hit_y,
    output logic signed [31:0]  hit_z,
    output logic [32:0]         hit_range,
    output logic                overflow
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DOT   = 8'b0000_0010,
        ST_PERP  = 8'b0000_0100,
        ST_SQ    = 8'b0000_1000,
        ST_SQRT  = 8'b0001_0000,
        ST_SCORE = 8'b0010_0000,
        ST_UPD   = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // working registers
    rpn_pkg::pt_entry_t ent_reg, ent_next;
    logic signed [32:0] op_reg [3];
    logic signed [32:0] op_next [3];
    logic [31:0]        pmag_reg [3];
    logic [31:0]        pmag_next [3];
    logic               huge_reg, huge_next;
    logic signed [50:0] t_reg, t_next;
    logic [1:0]         idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic [65:0]        acc_reg, acc_next;
    logic [35:0]        rem_reg, rem_next;
    logic [32:0]        root_reg, root_next;
    logic [5:0]         step_reg, step_next;
    logic [32:0]        dist_reg, dist_next;
    logic [32:0]        range_reg, range_next;
    logic [50:0]        prod_reg, prod_next;

    // best of the current query
    logic [33:0]        lead_score_reg, lead_score_next;
    logic [15:0]        best_pos_reg, best_pos_next;
    logic signed [31:0] best_px_reg, best_px_next;
    logic signed [31:0] best_py_reg, best_py_next;
    logic signed [31:0] best_pz_reg, best_pz_next;
    logic [32:0]        best_range_reg, best_range_next;
    logic               have_hit_reg, have_hit_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               found_reg;
    logic [15:0]        best_index_reg;
    logic signed [31:0] hit_x_reg, hit_y_reg, hit_z_reg;
    logic [32:0]        hit_range_reg;
    logic               overflow_reg;
    logic               out_load;

    // shared datapath signals
    logic signed [35:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [15:0] dir_sel;
    logic signed [32:0] op_sel;
    logic signed [37:0] perp_full;
    logic [37:0]        perp_abs;
    logic [31:0]        sq_in;
    logic [63:0]        sq_out;
    logic [35:0]        rem_sh;
    logic [35:0]        trial;
    logic               ge;
    logic [33:0]        score;
    logic signed [32:0] op_ld [3];

    // selected component
    always_comb
    begin
        case (idx_reg)
            2'd0:    begin dir_sel = cfg.dir_x; op_sel = op_reg[0]; end
            2'd1:    begin dir_sel = cfg.dir_y; op_sel = op_reg[1]; end
            default: begin dir_sel = cfg.dir_z; op_sel = op_reg[2]; end
        endcase
    end

    // signed multiplier shared by the dot product and the projection
    always_comb
    begin
        if (state_reg == ST_DOT)
        begin
            mul_a = {{3{op_sel[32]}}, op_sel};
        end
        else
        begin
            mul_a = t_reg[50:15];
        end
        mul_b = dir_sel;
        mul_p = mul_a * mul_b;
    end

    // perpendicular component and its magnitude
    always_comb
    begin
        perp_full = {{5{op_sel[32]}}, op_sel} - {mul_p[51], mul_p[51:15]};
        perp_abs  = perp_full[37] ? 38'(-perp_full) : perp_full;
    end

    // squaring multiplier
    always_comb
    begin
        logic [32:0] oa;
        oa = 33'(op_sel[32] ? -op_sel : op_sel);
        if (phase_reg)
        begin
            sq_in = oa[31:0];
        end
        else
        begin
            sq_in = pmag_reg[idx_reg];
        end
        sq_out = sq_in * sq_in;
    end

    // one restoring square root step
    always_comb
    begin
        rem_sh = {rem_reg[33:0], acc_reg[65:64]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    assign score = 34'(dist_reg) + 34'(prod_reg[50:rpn_pkg::SCORE_SHIFT]);

    // origin offsets of the entry at the head of the queue
    always_comb
    begin
        op_ld[0] = 33'(head.px) - 33'(cfg.origin_x);
        op_ld[1] = 33'(head.py) - 33'(cfg.origin_y);
        op_ld[2] = 33'(head.pz) - 33'(cfg.origin_z);
    end

    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign out_load = (state_reg == ST_FIN) && ent_reg.last
                      && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        op_next     = op_reg;
        pmag_next   = pmag_reg;
        huge_next   = huge_reg;
        t_next      = t_reg;
        idx_next    = idx_reg;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        dist_next   = dist_reg;
        range_next  = range_reg;
        prod_next   = prod_reg;
        lead_score_next = lead_score_reg;
        best_pos_next   = best_pos_reg;
        best_px_next    = best_px_reg;
        best_py_next    = best_py_reg;
        best_pz_next    = best_pz_reg;
        best_range_next = best_range_reg;
        have_hit_next   = have_hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    ent_next  = head;
                    op_next   = op_ld;
                    t_next    = '0;
                    idx_next  = '0;
                    huge_next = 1'b0;
                    state_next = head.score_en ? ST_DOT : ST_FIN;
                end
            end
            ST_DOT:
            begin
                t_next = t_reg + $signed(mul_p[50:0]);
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = ST_PERP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_PERP:
            begin
                pmag_next[idx_reg] = perp_abs[31:0];
                if (perp_abs[37:32] != '0)
                begin
                    huge_next = 1'b1;
                end
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    phase_next = 1'b0;
                    acc_next   = '0;
                    if (huge_next)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SQ;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SQ:
            begin
                acc_next = acc_reg + 66'(sq_out);
                if (idx_reg == 2'd2)
                begin
                    idx_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SQRT:
            begin
                rem_next  = ge ? (rem_sh - trial) : rem_sh;
                root_next = {root_reg[31:0], ge};
                acc_next  = {acc_reg[63:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd32)
                begin
                    if (!phase_reg)
                    begin
                        dist_next = root_next;
                        if (root_next > 33'(cfg.max_dist))
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                            acc_next   = '0;
                            state_next = ST_SQ;
                        end
                    end
                    else
                    begin
                        range_next = root_next;
                        state_next = ST_SCORE;
                    end
                end
            end
            ST_SCORE:
            begin
                prod_next  = range_reg * rpn_pkg::SCORE_K;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (score < lead_score_reg)
                begin
                    lead_score_next = score;
                    best_pos_next   = ent_reg.pos;
                    best_px_next    = ent_reg.px;
                    best_py_next    = ent_reg.py;
                    best_pz_next    = ent_reg.pz;
                    best_range_next = range_reg;
                    have_hit_next   = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ent_reg.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_load)
                begin
                    lead_score_next = '1;
                    best_pos_next   = '0;
                    best_px_next    = '0;
                    best_py_next    = '0;
                    best_pz_next    = '0;
                    best_range_next = '0;
                    have_hit_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and best state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lead_score_reg <= '1;
            best_pos_reg   <= '0;
            best_px_reg    <= '0;
            best_py_reg    <= '0;
            best_pz_reg    <= '0;
            best_range_reg <= '0;
            have_hit_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lead_score_reg <= lead_score_next;
            best_pos_reg   <= best_pos_next;
            best_px_reg    <= best_px_next;
            best_py_reg    <= best_py_next;
            best_pz_reg    <= best_pz_next;
            best_range_reg <= best_range_next;
            have_hit_reg   <= have_hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        op_reg    <= op_next;
        pmag_reg  <= pmag_next;
        huge_reg  <= huge_next;
        t_reg     <= t_next;
        idx_reg   <= idx_next;
        phase_reg <= phase_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        step_reg  <= step_next;
        dist_reg  <= dist_next;
        range_reg <= range_next;
        prod_reg  <= prod_next;
    end

    // result beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            found_reg      <= have_hit_reg;
            best_index_reg <= best_pos_reg;
            hit_x_reg      <= best_px_reg;
            hit_y_reg      <= best_py_reg;
            hit_z_reg      <= best_pz_reg;
            hit_range_reg  <= best_range_reg;
            overflow_reg   <= ent_reg.ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign best_index = best_index_reg;
    assign hit_x      = hit_x_reg;
    assign hit_y      = hit_y_reg;
    assign hit_z      = hit_z_reg;
    assign hit_range  = hit_range_reg;
    assign overflow   = overflow_reg;

endmodule

// File: hw/rtl/ray_pick_nearest_point.sv
// top level of the ray pick of the nearest point
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | point_x, point_y, point_z, last_point
//  out     | out_valid / out_stall| found, best_index, hit_x/y/z, hit_range,
//          |                      | overflow
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// in the back end a scored point runs 3 dot product, 3 projection, 3 squaring
// steps and a 33 step square root; within max_dist 3 more squaring steps and a
// second root on the shared unit, then score and compare; overflow points skip this.
// the front takes one beat a cycle into a 4 deep queue and stalls when full.
// reset (rst_n low) clears the query state and loads the default ray.
// a result beat waits in the output register while out_stall is high.
`timescale 1ns / 1ps
module ray_pick_nearest_point
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    input  logic                last_point,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [15:0]         best_index,
    output logic signed [31:0]  hit_x,
    output logic signed [31:0]  hit_y,
    output logic signed [31:0]  hit_z,
    output logic [32:0]         hit_range,
    output logic                overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    rpn_pkg::ray_cfg_t  cfg_reg, cfg_next;
    rpn_pkg::q_stat_t   q_stat;
    rpn_pkg::pt_entry_t push_data;
    rpn_pkg::pt_entry_t head;
    logic               push;
    logic               pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rpn_pkg::REG_ORIGIN_X: cfg_next.origin_x = cfg_data;
                rpn_pkg::REG_ORIGIN_Y: cfg_next.origin_y = cfg_data;
                rpn_pkg::REG_ORIGIN_Z: cfg_next.origin_z = cfg_data;
                rpn_pkg::REG_DIR_X:    cfg_next.dir_x    = cfg_data[15:0];
                rpn_pkg::REG_DIR_Y:    cfg_next.dir_y    = cfg_data[15:0];
                rpn_pkg::REG_DIR_Z:    cfg_next.dir_z    = cfg_data[15:0];
                rpn_pkg::REG_MAX_DIST: cfg_next.max_dist = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.dir_x    <= 16'sd32767;
            cfg_reg.dir_y    <= '0;
            cfg_reg.dir_z    <= '0;
            cfg_reg.max_dist <= 32'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    rpn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .last_point (last_point),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    // point queue
    rpn_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // back end
    rpn_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .best_index (best_index),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z),
        .hit_range  (hit_range),
        .overflow   (overflow)
    );

endmodule

// File: tb/ray_pick_nearest_point_test.sv
// testbench for the ray pick of the nearest point: directed and random queries checked by a predictor
`timescale 1ns / 1ps
module ray_pick_nearest_point_test;

    // unused register slot, writes there must be ignored
    localparam logic [2:0] REG_NONE      = 3'd7;
    localparam int         WATCHDOG_MAX  = 4000;
    localparam int         SETTLE_CYCLES = 120;
    localparam longint     PERP_LIMIT    = 64'sd4294967295;

    typedef struct {
        bit        found;
        bit [15:0] index;
        bit [31:0] x;
        bit [31:0] y;
        bit [31:0] z;
        bit [32:0] range;
        bit        ovf;
    } pick_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;
    logic               out_valid;
    logic               out_stall;
    logic               found;
    logic [15:0]        best_index;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic [32:0]        hit_range;
    logic               overflow;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // predictor copy of the ray
    logic signed [31:0] ray_ox, ray_oy, ray_oz;
    logic signed [15:0] ray_dx, ray_dy, ray_dz;
    logic [31:0]        ray_max;

    // predictor copy of the query state
    logic [33:0]        lead_score;
    logic [15:0]        best_pos;
    logic [31:0]        best_px, best_py, best_pz;
    logic [32:0]        best_range;
    bit                 have_hit;
    logic [16:0]        pt_count;
    bit                 cnt_ovf;

    pick_t expected_picks[$];
    int    failures;
    int    idle_cycles;
    bit    no_idle;
    bit    quiet_out;

    ray_pick_nearest_point uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .found      (found),
        .best_index (best_index),
        .hit_x      (hit_x),
        .hit_y      (hit_y),
        .hit_z      (hit_z),
        .hit_range  (hit_range),
        .overflow   (overflow),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // floor square root of a 66 bit value
    function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
        logic [32:0] root;
        logic [32:0] trial;
        logic [67:0] sq;
        int i;
        root = '0;
        for (i = 32; i >= 0; i--)
        begin
            trial = root | (33'd1 << i);
            sq = {35'd0, trial} * {35'd0, trial};
            if (sq <= {2'b00, v})
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [65:0] sum_squares(input longint a, input longint b,
                                                input longint c);
        logic [65:0] ma, mb, mc;
        ma = 66'(a < 0 ? -a : a);
        mb = 66'(b < 0 ? -b : b);
        mc = 66'(c < 0 ? -c : c);
        return ma * ma + mb * mb + mc * mc;
    endfunction

    function automatic void clear_query();
        lead_score = '1;
        best_pos   = '0;
        best_px    = '0;
        best_py    = '0;
        best_pz    = '0;
        best_range = '0;
        have_hit   = 0;
        pt_count   = '0;
        cnt_ovf    = 0;
    endfunction

    // distance to the ray line, range from origin, and the min compare
    function automatic void score_candidate(input logic signed [31:0] px,
                                            input logic signed [31:0] py,
                                            input logic signed [31:0] pz,
                                            input logic [15:0] pos);
        longint      op[3];
        longint      dv[3];
        longint      perp[3];
        longint      dot, t16;
        logic [32:0] perp_len, rng;
        logic [65:0] sc;
        int k;
        op[0] = longint'(px) - longint'(ray_ox);
        op[1] = longint'(py) - longint'(ray_oy);
        op[2] = longint'(pz) - longint'(ray_oz);
        dv[0] = longint'(ray_dx);
        dv[1] = longint'(ray_dy);
        dv[2] = longint'(ray_dz);
        dot = op[0] * dv[0] + op[1] * dv[1] + op[2] * dv[2];
        t16 = dot >>> 15;
        for (k = 0; k < 3; k++)
        begin
            perp[k] = op[k] - ((t16 * dv[k]) >>> 15);
            if (perp[k] > PERP_LIMIT || perp[k] < -PERP_LIMIT)
                return;
        end
        perp_len = floor_sqrt(sum_squares(perp[0], perp[1], perp[2]));
        if (perp_len > {1'b0, ray_max})
            return;
        rng = floor_sqrt(sum_squares(op[0], op[1], op[2]));
        sc = 66'(perp_len) + ((66'(rng) * 66'(rpn_pkg::SCORE_K)) >> rpn_pkg::SCORE_SHIFT);
        if (sc < 66'(lead_score))
        begin
            lead_score = sc[33:0];
            best_pos   = pos;
            best_px    = px;
            best_py    = py;
            best_pz    = pz;
            best_range = rng;
            have_hit   = 1;
        end
    endfunction

    // one accepted point, with the pick it closes
    function automatic void predict_point(input logic signed [31:0] px,
                                          input logic signed [31:0] py,
                                          input logic signed [31:0] pz,
                                          input bit last);
        pick_t p;
        if (pt_count < 17'(rpn_pkg::POINT_CAP))
        begin
            score_candidate(px, py, pz, pt_count[15:0]);
            pt_count++;
        end
        else
            cnt_ovf = 1;
        if (last)
        begin
            p.found = have_hit;
            p.index = have_hit ? best_pos : '0;
            p.x     = have_hit ? best_px : '0;
            p.y     = have_hit ? best_py : '0;
            p.z     = have_hit ? best_pz : '0;
            p.range = have_hit ? best_range : '0;
            p.ovf   = cnt_ovf;
            expected_picks.insert(expected_picks.size(), p);
            clear_query();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side stall pattern
    always @(posedge clk)
    begin : stall_drive
        int hold;
        if (!rst_n)
            hold = 0;
        else if (hold > 0)
            hold--;
        else
        begin
            out_stall <= !quiet_out && ($urandom_range(0, 99) < 30);
            hold = pick_gap();
        end
    end

    // result check, sampled mid cycle so the beat is stable
    always @(negedge clk)
    begin : pick_check
        pick_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected result beat found=%0d index=%0d", $time,
                         found, best_index);
                failures++;
            end
            else
            begin
                e = expected_picks.pop_front();
                if (found !== e.found || best_index !== e.index || hit_x !== e.x ||
                    hit_y !== e.y || hit_z !== e.z || hit_range !== e.range ||
                    overflow !== e.ovf)
                begin
                    $display("%0t: mismatch expected found=%0d idx=%0d x=%h y=%h z=%h rng=%h ovf=%0d",
                             $time, e.found, e.index, e.x, e.y, e.z, e.range, e.ovf);
                    $display("%0t:          actual found=%0d idx=%0d x=%h y=%h z=%h rng=%h ovf=%0d",
                             $time, found, best_index, hit_x, hit_y, hit_z, hit_range,
                             overflow);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("%0t: watchdog expired", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input bit last);
        int  gap;
        bit  st;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_x    <= px;
        point_y    <= py;
        point_z    <= pz;
        last_point <= last;
        in_valid   <= 1'b1;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end
        while (st);
        predict_point(px, py, pz, last);
    endtask

    // wait for every pick, then let a scored point run out before config writes
    task automatic drain_picks();
        in_valid <= 1'b0;
        wait (expected_picks.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register beat; the caller drops cfg_valid after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        bit rdy;
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end
        while (!rdy);
        case (idx)
            rpn_pkg::REG_ORIGIN_X: ray_ox = data;
            rpn_pkg::REG_ORIGIN_Y: ray_oy = data;
            rpn_pkg::REG_ORIGIN_Z: ray_oz = data;
            rpn_pkg::REG_DIR_X:    ray_dx = data[15:0];
            rpn_pkg::REG_DIR_Y:    ray_dy = data[15:0];
            rpn_pkg::REG_DIR_Z:    ray_dz = data[15:0];
            rpn_pkg::REG_MAX_DIST: ray_max = data;
            default: ;
        endcase
    endtask

    task automatic set_ray(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [15:0] dx,
                           input logic [15:0] dy, input logic [15:0] dz,
                           input logic [31:0] maxd);
        write_reg(rpn_pkg::REG_ORIGIN_X, ox);
        write_reg(rpn_pkg::REG_ORIGIN_Y, oy);
        write_reg(rpn_pkg::REG_ORIGIN_Z, oz);
        write_reg(rpn_pkg::REG_DIR_X, {{16{dx[15]}}, dx});
        write_reg(rpn_pkg::REG_DIR_Y, {{16{dy[15]}}, dy});
        write_reg(rpn_pkg::REG_DIR_Z, {{16{dz[15]}}, dz});
        write_reg(rpn_pkg::REG_MAX_DIST, maxd);
        cfg_valid <= 1'b0;
    endtask

    // a point near the ray at parameter t with a bounded offset
    task automatic send_near_point(input int spread, input bit last);
        longint t, nx, ny, nz;
        t  = longint'($urandom_range(0, 800000)) - 200000;
        nx = longint'($urandom_range(0, 2 * spread)) - spread;
        ny = longint'($urandom_range(0, 2 * spread)) - spread;
        nz = longint'($urandom_range(0, 2 * spread)) - spread;
        send_point(32'(longint'(ray_ox) + ((t * ray_dx) >>> 15) + nx),
                   32'(longint'(ray_oy) + ((t * ray_dy) >>> 15) + ny),
                   32'(longint'(ray_oz) + ((t * ray_dz) >>> 15) + nz), last);
    endtask

    // extremes, tie and no candidate under the reset ray, huge perpendicular on a set ray
    task automatic test_directed();
        send_point(32'h0001_0000, 32'h0000_8000, 32'h0, 1'b1);
        send_point(32'h0005_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0005_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'h0, 32'h0100_0000, 32'h0, 1'b1);
        send_point(32'h7fff_ffff, 32'h0, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h0, 32'hffff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_point(32'h0002_0000, 32'h0, 32'h0000_4000, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0000_4000, 1'b1);
        drain_picks();
        write_reg(REG_NONE, 32'h1234_5678);
        set_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000, 16'h8000, 16'h8000,
                32'hffff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        drain_picks();
        set_ray(32'h8000_0000, 32'h0, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h7fff_ffff, 1'b0);
        send_point(32'h8001_0000, 32'h0, 32'h7fff_ffff, 1'b1);
        drain_picks();
    endtask

    // random rays, each followed by queries of random length
    task automatic test_random_queries();
        int phase, sent, qlen, k, spread;
        logic [15:0] dx, dy, dz;
        logic [31:0] maxd;
        for (phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 4))
                0: begin dx = 16'd32767; dy = 16'd0; dz = 16'd0; end
                1: begin dx = 16'd0; dy = 16'h8000; dz = 16'd0; end
                2: begin dx = 16'd23170; dy = -16'sd23170; dz = 16'd0; end
                3: begin dx = 16'd18918; dy = 16'd18918; dz = -16'sd18918; end
                default:
                begin
                    dx = 16'($urandom);
                    dy = 16'($urandom);
                    dz = 16'($urandom);
                end
            endcase
            maxd = (phase == 1) ? 32'h0 : (phase == 2) ? 32'hffff_ffff
                 : $urandom_range(1, 32'h0008_0000);
            spread = $urandom_range(1, 32'h0004_0000);
            if (phase == 3)
                set_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, dx, dy, dz, maxd);
            else
                set_ray($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
                        $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
                        $urandom, dx, dy, dz, maxd);
            no_idle   = (phase == 4);
            quiet_out = (phase == 5);
            sent = 0;
            while (sent < 240)
            begin
                qlen = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40)
                     : $urandom_range(1, 12);
                for (k = 0; k < qlen; k++)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_point($urandom, $urandom, $urandom, k == qlen - 1);
                    else
                        send_near_point(spread, k == qlen - 1);
                end
                sent += qlen;
            end
            drain_picks();
        end
        no_idle   = 0;
        quiet_out = 0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        point_x    = '0;
        point_y    = '0;
        point_z    = '0;
        last_point = 1'b0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        failures   = 0;
        idle_cycles = 0;
        no_idle    = 0;
        quiet_out  = 0;
        ray_ox = '0;
        ray_oy = '0;
        ray_oz = '0;
        ray_dx = 16'sd32767;
        ray_dy = '0;
        ray_dz = '0;
        ray_max = 32'h0001_0000;
        clear_query();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_queries();

        drain_picks();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
